// ----- hdl/rlc_pkg.sv -----
// shared types and constants of the rectangle line clipper
`default_nettype none

package rlc_pkg;

	localparam logic [3:0] CODE_LEFT   = 4'd1;
	localparam logic [3:0] CODE_RIGHT  = 4'd2;
	localparam logic [3:0] CODE_BOTTOM = 4'd4;
	localparam logic [3:0] CODE_TOP    = 4'd8;

	localparam logic [2:0] MAX_MOVES = 3'd4;

	localparam logic [1:0] REG_WINDOW_LEFT   = 2'd0;
	localparam logic [1:0] REG_WINDOW_TOP    = 2'd1;
	localparam logic [1:0] REG_WINDOW_RIGHT  = 2'd2;
	localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SETUP,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic mul;
		logic div_start;
		logic update;
		logic finish;
		logic accept;
	} cmd_t;

	typedef struct packed {
		logic all_zero;
		logic share;
		logic div_done;
	} status_t;

endpackage

`default_nettype wire

// ----- hdl/rlc_divider.sv -----
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module rlc_divider #(
	parameter int W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [2*W-1:0]   dividend,
	input  wire logic [W-1:0]     divisor,
	output logic      [2*W-1:0]   quotient,
	output logic                  done
);

	localparam int CW = $clog2(2 * W + 1);

	logic [2*W-1:0] quo_q;
	logic [W-1:0]   rem_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     rem_shift;
	logic [W:0]     rem_diff;
	logic           take;

	assign rem_shift = {rem_q, quo_q[2*W-1]};
	assign rem_diff  = rem_shift - {1'b0, divisor};
	assign take      = rem_shift >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(2 * W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[2*W-2:0], take};
			rem_q <= take ? rem_diff[W-1:0] : rem_shift[W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ----- hdl/rlc_datapath.sv -----
// window registers, endpoint registers, crossing arithmetic and result register
`default_nettype none

module rlc_datapath #(
	parameter int W = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [W-1:0]         cfg_data,
	input  wire logic [W-1:0]         start_x,
	input  wire logic [W-1:0]         start_y,
	input  wire logic [W-1:0]         end_x,
	input  wire logic [W-1:0]         end_y,
	input  wire rlc_pkg::cmd_t        cmd,
	output rlc_pkg::status_t          status,
	output logic                      accepted,
	output logic [W-1:0]              clip_start_x,
	output logic [W-1:0]              clip_start_y,
	output logic [W-1:0]              clip_end_x,
	output logic [W-1:0]              clip_end_y
);

	localparam int SW = 2 * W + 2;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	logic signed [W-1:0] win_left_q, win_top_q, win_right_q, win_bottom_q;
	logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [W-1:0]        orig_sx_q, orig_sy_q, orig_ex_q, orig_ey_q;

	logic signed [W-1:0] base_q, fixed_q;
	logic [W-1:0]        mag_a_q, mag_b_q, span_q;
	logic                neg_q, span_zero_q, edge_y_q, first_q;
	logic [2*W-1:0]      prod_q;

	logic                res_acc_q;
	logic [W-1:0]        res_sx_q, res_sy_q, res_ex_q, res_ey_q;

	logic [3:0]          c1, c2, co;
	logic signed [W-1:0] s_base, s_fixed, s_a0, s_a1, s_o0, s_o1, s_p0, s_p1;
	logic                s_edge_y;
	logic signed [W:0]   delta, offset, span;
	logic [W:0]          abs_d, abs_o, abs_s;
	logic [2*W-1:0]      quot, q_use;
	logic                div_done;
	logic signed [SW-1:0] base_ext, q_ext, sum;
	logic signed [W-1:0] sat;

	function automatic logic [3:0] outcode(
		input logic signed [W-1:0] x,
		input logic signed [W-1:0] y,
		input logic signed [W-1:0] l,
		input logic signed [W-1:0] t,
		input logic signed [W-1:0] r,
		input logic signed [W-1:0] b
	);
		logic [3:0] c;
		c = 4'd0;
		if (x < l)
			c = c | rlc_pkg::CODE_LEFT;
		else if (x > r)
			c = c | rlc_pkg::CODE_RIGHT;
		if (y < t)
			c = c | rlc_pkg::CODE_TOP;
		else if (y > b)
			c = c | rlc_pkg::CODE_BOTTOM;
		return c;
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_top_q    <= '0;
			win_right_q  <= '0;
			win_bottom_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlc_pkg::REG_WINDOW_LEFT:   win_left_q   <= cfg_data;
				rlc_pkg::REG_WINDOW_TOP:    win_top_q    <= cfg_data;
				rlc_pkg::REG_WINDOW_RIGHT:  win_right_q  <= cfg_data;
				rlc_pkg::REG_WINDOW_BOTTOM: win_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign c1 = outcode(x1_q, y1_q, win_left_q, win_top_q, win_right_q, win_bottom_q);
	assign c2 = outcode(x2_q, y2_q, win_left_q, win_top_q, win_right_q, win_bottom_q);
	assign co = (c1 != 4'd0) ? c1 : c2;

	// edge selection in the order top, bottom, right, left
	always_comb begin
		if ((co & rlc_pkg::CODE_TOP) != 4'd0) begin
			s_edge_y = 1'b1;
			s_fixed  = win_top_q;
		end else if ((co & rlc_pkg::CODE_BOTTOM) != 4'd0) begin
			s_edge_y = 1'b1;
			s_fixed  = win_bottom_q;
		end else if ((co & rlc_pkg::CODE_RIGHT) != 4'd0) begin
			s_edge_y = 1'b0;
			s_fixed  = win_right_q;
		end else begin
			s_edge_y = 1'b0;
			s_fixed  = win_left_q;
		end
		if (s_edge_y) begin
			s_base = x1_q;
			s_a0 = x1_q; s_a1 = x2_q;
			s_o0 = y1_q; s_o1 = s_fixed;
			s_p0 = y1_q; s_p1 = y2_q;
		end else begin
			s_base = y1_q;
			s_a0 = y1_q; s_a1 = y2_q;
			s_o0 = x1_q; s_o1 = s_fixed;
			s_p0 = x1_q; s_p1 = x2_q;
		end
	end

	assign delta  = {s_a1[W-1], s_a1} - {s_a0[W-1], s_a0};
	assign offset = {s_o1[W-1], s_o1} - {s_o0[W-1], s_o0};
	assign span   = {s_p1[W-1], s_p1} - {s_p0[W-1], s_p0};
	assign abs_d  = delta[W]  ? -delta  : delta;
	assign abs_o  = offset[W] ? -offset : offset;
	assign abs_s  = span[W]   ? -span   : span;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			base_q      <= s_base;
			fixed_q     <= s_fixed;
			edge_y_q    <= s_edge_y;
			first_q     <= (c1 != 4'd0);
			mag_a_q     <= abs_d[W-1:0];
			mag_b_q     <= abs_o[W-1:0];
			span_q      <= abs_s[W-1:0];
			span_zero_q <= (span == '0);
			neg_q       <= delta[W] ^ offset[W] ^ span[W];
		end
		if (cmd.mul)
			prod_q <= mag_a_q * mag_b_q;
	end

	rlc_divider #(
		.W(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (span_q),
		.quotient (quot),
		.done     (div_done)
	);

	assign q_use    = span_zero_q ? '0 : quot;
	assign base_ext = SW'(base_q);
	assign q_ext    = {2'b00, q_use};
	assign sum      = neg_q ? base_ext - q_ext : base_ext + q_ext;
	assign sat      = (sum > SAT_HI) ? SAT_HI[W-1:0] :
	                  (sum < SAT_LO) ? SAT_LO[W-1:0] : sum[W-1:0];

	// endpoint registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= start_x;
			y1_q <= start_y;
			x2_q <= end_x;
			y2_q <= end_y;
			orig_sx_q <= start_x;
			orig_sy_q <= start_y;
			orig_ex_q <= end_x;
			orig_ey_q <= end_y;
		end else if (cmd.update) begin
			if (first_q) begin
				x1_q <= edge_y_q ? sat : fixed_q;
				y1_q <= edge_y_q ? fixed_q : sat;
			end else begin
				x2_q <= edge_y_q ? sat : fixed_q;
				y2_q <= edge_y_q ? fixed_q : sat;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_acc_q <= cmd.accept;
			res_sx_q  <= cmd.accept ? x1_q : orig_sx_q;
			res_sy_q  <= cmd.accept ? y1_q : orig_sy_q;
			res_ex_q  <= cmd.accept ? x2_q : orig_ex_q;
			res_ey_q  <= cmd.accept ? y2_q : orig_ey_q;
		end
	end

	assign status.all_zero = ((c1 | c2) == 4'd0);
	assign status.share    = ((c1 & c2) != 4'd0);
	assign status.div_done = div_done;

	assign accepted     = res_acc_q;
	assign clip_start_x = res_sx_q;
	assign clip_start_y = res_sy_q;
	assign clip_end_x   = res_ex_q;
	assign clip_end_y   = res_ey_q;

endmodule

`default_nettype wire

// ----- hdl/rlc_ctrl.sv -----
// controller state machine, move counter and output beat flag
`default_nettype none

module rlc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire rlc_pkg::status_t    status,
	output rlc_pkg::cmd_t            cmd
);

	rlc_pkg::state_t state_q, state_next;
	logic [2:0]      rnd_q;
	logic            acc_q;
	logic            out_valid_q;
	logic            slot_free;
	logic            give_up;

	assign slot_free = !out_valid_q || out_ready;
	assign give_up   = status.share || (rnd_q == rlc_pkg::MAX_MOVES);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			rlc_pkg::ST_IDLE:      if (in_valid) state_next = rlc_pkg::ST_DECIDE;
			rlc_pkg::ST_DECIDE: begin
				if (status.all_zero || give_up)
					state_next = rlc_pkg::ST_FINISH;
				else
					state_next = rlc_pkg::ST_SETUP;
			end
			rlc_pkg::ST_SETUP:     state_next = rlc_pkg::ST_MUL;
			rlc_pkg::ST_MUL:       state_next = rlc_pkg::ST_DIV_START;
			rlc_pkg::ST_DIV_START: state_next = rlc_pkg::ST_DIV_WAIT;
			rlc_pkg::ST_DIV_WAIT:  if (status.div_done) state_next = rlc_pkg::ST_UPDATE;
			rlc_pkg::ST_UPDATE:    state_next = rlc_pkg::ST_DECIDE;
			rlc_pkg::ST_FINISH:    if (slot_free) state_next = rlc_pkg::ST_IDLE;
			default:               state_next = rlc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rlc_pkg::ST_IDLE:      cmd.load      = in_valid;
			rlc_pkg::ST_SETUP:     cmd.setup     = 1'b1;
			rlc_pkg::ST_MUL:       cmd.mul       = 1'b1;
			rlc_pkg::ST_DIV_START: cmd.div_start = 1'b1;
			rlc_pkg::ST_UPDATE:    cmd.update    = 1'b1;
			rlc_pkg::ST_FINISH:    cmd.finish    = slot_free;
			default: ;
		endcase
		cmd.accept = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlc_pkg::ST_IDLE;
			rnd_q       <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load)
				rnd_q <= '0;
			else if (cmd.update)
				rnd_q <= rnd_q + 3'd1;
			if (state_q == rlc_pkg::ST_DECIDE)
				acc_q <= status.all_zero;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == rlc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/rectangle_line_clipper_unit.sv -----
// top level of the rectangle line clipper
// Clips one segment per input beat against the window held in four
// registers (left, top, right, bottom), written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle,
// which the block itself does not enforce. All four reset to zero.
// Input beat on s_t*: both endpoints. Output beat on m_t*: accept flag and
// the clipped endpoints, or the original endpoints when rejected.
// Each segment needs k endpoint moves, where k is 0 to 4; each move is set
// by one pass through the bit-serial divider.
// One segment is in work at a time; s_tready is high only while the
// controller is idle, so a new segment is not taken before the last one
// has reached the output register.
// The result sits in an output register, so the next segment is taken
// while m_tvalid waits on m_tready; a stalled receiver holds the finished
// second segment until the register frees up.
// Reset clears the controller, the output flag and the window registers.
`default_nettype none

module rectangle_line_clipper_unit #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        s_tvalid,
	output logic                                             s_tready,
	// start_x, start_y, end_x, end_y
	input  wire logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                             m_tvalid,
	input  wire logic                                        m_tready,
	// accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y
	output logic [((4 * COORD_BITS + 8) / 8) * 8 - 1:0]     m_tdata,
	input  wire logic                                        cfg_we,
	input  wire logic [1:0]                                  cfg_index,
	input  wire logic [COORD_BITS-1:0]                       cfg_data
);

	localparam int W      = COORD_BITS;
	localparam int OUT_W  = ((4 * W + 8) / 8) * 8;
	localparam int PAD_W  = OUT_W - (4 * W + 1);

	rlc_pkg::cmd_t    cmd;
	rlc_pkg::status_t status;
	logic             accepted;
	logic [W-1:0]     clip_start_x, clip_start_y, clip_end_x, clip_end_y;

	rlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	rlc_datapath #(
		.W(W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start_x      (s_tdata[W-1:0]),
		.start_y      (s_tdata[2*W-1:W]),
		.end_x        (s_tdata[3*W-1:2*W]),
		.end_y        (s_tdata[4*W-1:3*W]),
		.cmd          (cmd),
		.status       (status),
		.accepted     (accepted),
		.clip_start_x (clip_start_x),
		.clip_start_y (clip_start_y),
		.clip_end_x   (clip_end_x),
		.clip_end_y   (clip_end_y)
	);

	assign m_tdata = {{PAD_W{1'b0}}, clip_end_y, clip_end_x, clip_start_y, clip_start_x,
	                  accepted};

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench of the rectangle line clipper: predicted clips checked beat by beat, random idling
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = 16;
	localparam int S_W = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int M_W = ((4 * COORD_BITS + 8) / 8) * 8;
	localparam longint COORD_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;
	localparam int END_WAIT = 200;

	// start_x in the lowest bits
	typedef struct packed {
		logic [COORD_BITS-1:0] end_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] start_x;
	} segment_t;

	// accepted in bit 0
	typedef struct packed {
		logic [COORD_BITS-1:0] clip_end_y;
		logic [COORD_BITS-1:0] clip_end_x;
		logic [COORD_BITS-1:0] clip_start_y;
		logic [COORD_BITS-1:0] clip_start_x;
		logic                  accepted;
	} clip_result_t;

	class clip_scoreboard;
		longint win_left, win_top, win_right, win_bottom;
		clip_result_t expected_clips[$];
		int errors;

		function new();
			win_left = 0;
			win_top = 0;
			win_right = 0;
			win_bottom = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [COORD_BITS-1:0] val);
			longint v;
			v = longint'($signed(val));
			case (idx)
				rlc_pkg::REG_WINDOW_LEFT: win_left = v;
				rlc_pkg::REG_WINDOW_TOP: win_top = v;
				rlc_pkg::REG_WINDOW_RIGHT: win_right = v;
				rlc_pkg::REG_WINDOW_BOTTOM: win_bottom = v;
				default: ;
			endcase
		endfunction

		function logic [3:0] outcode(longint x, longint y);
			logic [3:0] c;
			c = '0;
			if (x < win_left) c |= rlc_pkg::CODE_LEFT;
			else if (x > win_right) c |= rlc_pkg::CODE_RIGHT;
			if (y < win_top) c |= rlc_pkg::CODE_TOP;
			else if (y > win_bottom) c |= rlc_pkg::CODE_BOTTOM;
			return c;
		endfunction

		function longint saturate(longint v);
			if (v > COORD_HI) return COORD_HI;
			if (v < COORD_LO) return COORD_LO;
			return v;
		endfunction

		// base + delta * offset / span, quotient truncated toward zero
		function longint crossing(longint base, longint delta, longint offset, longint span);
			longint unsigned ua, ub, us, q;
			bit neg;
			ua = (delta < 0) ? -delta : delta;
			ub = (offset < 0) ? -offset : offset;
			us = (span < 0) ? -span : span;
			neg = ((delta < 0) != (offset < 0)) != (span < 0);
			if (us == 0) return saturate(base);
			q = (ua * ub) / us;
			if (q > (64'd1 << 40)) return neg ? COORD_LO : COORD_HI;
			return saturate(neg ? base - longint'(q) : base + longint'(q));
		endfunction

		function clip_result_t clip_segment(segment_t seg);
			longint x1, y1, x2, y2, nx, ny;
			logic [3:0] c1, c2, co;
			bit accept, decided;
			clip_result_t r;
			x1 = longint'($signed(seg.start_x));
			y1 = longint'($signed(seg.start_y));
			x2 = longint'($signed(seg.end_x));
			y2 = longint'($signed(seg.end_y));
			c1 = outcode(x1, y1);
			c2 = outcode(x2, y2);
			accept = 0;
			decided = 0;
			for (int i = 0; i < rlc_pkg::MAX_MOVES; i++) begin
				if ((c1 | c2) == 0) begin
					accept = 1;
					decided = 1;
					break;
				end
				if ((c1 & c2) != 0) begin
					decided = 1;
					break;
				end
				co = (c1 != 0) ? c1 : c2;
				if ((co & rlc_pkg::CODE_TOP) != 0) begin
					ny = win_top;
					nx = crossing(x1, x2 - x1, win_top - y1, y2 - y1);
				end else if ((co & rlc_pkg::CODE_BOTTOM) != 0) begin
					ny = win_bottom;
					nx = crossing(x1, x2 - x1, win_bottom - y1, y2 - y1);
				end else if ((co & rlc_pkg::CODE_RIGHT) != 0) begin
					nx = win_right;
					ny = crossing(y1, y2 - y1, win_right - x1, x2 - x1);
				end else begin
					nx = win_left;
					ny = crossing(y1, y2 - y1, win_left - x1, x2 - x1);
				end
				if (co == c1) begin
					x1 = nx;
					y1 = ny;
					c1 = outcode(x1, y1);
				end else begin
					x2 = nx;
					y2 = ny;
					c2 = outcode(x2, y2);
				end
			end
			if (!decided) accept = (c1 | c2) == 0;
			r.accepted = accept;
			if (accept) begin
				r.clip_start_x = x1[COORD_BITS-1:0];
				r.clip_start_y = y1[COORD_BITS-1:0];
				r.clip_end_x = x2[COORD_BITS-1:0];
				r.clip_end_y = y2[COORD_BITS-1:0];
			end else begin
				r.clip_start_x = seg.start_x;
				r.clip_start_y = seg.start_y;
				r.clip_end_x = seg.end_x;
				r.clip_end_y = seg.end_y;
			end
			return r;
		endfunction

		function void note_segment(segment_t seg);
			expected_clips.push_back(clip_segment(seg));
		endfunction

		function void check_result(logic [M_W-1:0] beat);
			clip_result_t got, want;
			got = clip_result_t'(beat[4*COORD_BITS:0]);
			if (expected_clips.size() == 0) begin
				$error("result beat with no segment waiting: %h", beat);
				errors++;
				return;
			end
			want = expected_clips.pop_front();
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
				errors++;
			end
			if (got.clip_start_x !== want.clip_start_x) begin
				$error("clip_start_x: expected %0d, got %0d",
					$signed(want.clip_start_x), $signed(got.clip_start_x));
				errors++;
			end
			if (got.clip_start_y !== want.clip_start_y) begin
				$error("clip_start_y: expected %0d, got %0d",
					$signed(want.clip_start_y), $signed(got.clip_start_y));
				errors++;
			end
			if (got.clip_end_x !== want.clip_end_x) begin
				$error("clip_end_x: expected %0d, got %0d",
					$signed(want.clip_end_x), $signed(got.clip_end_x));
				errors++;
			end
			if (got.clip_end_y !== want.clip_end_y) begin
				$error("clip_end_y: expected %0d, got %0d",
					$signed(want.clip_end_y), $signed(got.clip_end_y));
				errors++;
			end
		endfunction

		function int pending();
			return expected_clips.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = rlc_pkg::REG_WINDOW_LEFT;
	logic [COORD_BITS-1:0] cfg_data = '0;

	bit tx_gaps = 0;
	bit rx_stalls = 0;
	int stall_left = 0;

	clip_scoreboard sb = new();

	rectangle_line_clipper_unit #(.COORD_BITS(COORD_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready === 1'b1) sb.note_segment(segment_t'(s_tdata));
			if (m_tvalid === 1'b1 && m_tready) sb.check_result(m_tdata);
		end
	end

	// receiver stalls: mostly short, a few long
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!rx_stalls) begin
			m_tready <= 1'b1;
		end else begin
			case ($urandom_range(99)) inside
				[0:69]: m_tready <= 1'b1;
				[70:94]: begin
					stall_left = $urandom_range(2) ;
					m_tready <= 1'b0;
				end
				default: begin
					stall_left = $urandom_range(40, 10);
					m_tready <= 1'b0;
				end
			endcase
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!tx_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic segment_t make_seg(int sx, int sy, int ex, int ey);
		segment_t seg;
		seg.start_x = sx[COORD_BITS-1:0];
		seg.start_y = sy[COORD_BITS-1:0];
		seg.end_x = ex[COORD_BITS-1:0];
		seg.end_y = ey[COORD_BITS-1:0];
		return seg;
	endfunction

	// near the window most of the time, on its edges often, anywhere otherwise
	function automatic logic [COORD_BITS-1:0] rand_coord(longint a, longint b);
		longint lo, hi, margin, v;
		int r;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		margin = (hi - lo) / 2 + 20;
		r = $urandom_range(99);
		if (r < 65) begin
			v = lo - margin + longint'($urandom_range(int'(hi - lo + 2 * margin)));
		end else if (r < 80) begin
			case ($urandom_range(3))
				0: v = lo;
				1: v = hi;
				2: v = lo - 1;
				default: v = hi + 1;
			endcase
		end else begin
			v = longint'($signed(16'($urandom())));
		end
		if (v > COORD_HI) v = COORD_HI;
		if (v < COORD_LO) v = COORD_LO;
		return v[COORD_BITS-1:0];
	endfunction

	task automatic send_segment(segment_t seg);
		int gap;
		s_tdata <= seg;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, longint val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[COORD_BITS-1:0];
		@(posedge clk);
	endtask

	task automatic set_window(longint l, longint t, longint r, longint b);
		drain();
		write_reg(rlc_pkg::REG_WINDOW_LEFT, l);
		write_reg(rlc_pkg::REG_WINDOW_TOP, t);
		write_reg(rlc_pkg::REG_WINDOW_RIGHT, r);
		write_reg(rlc_pkg::REG_WINDOW_BOTTOM, b);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_segments(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) begin
				tx_gaps = $urandom_range(3) != 0;
				rx_stalls = $urandom_range(3) != 0;
			end
			// hold off until the block has emptied
			if (i == n / 2) drain();
			send_segment(make_seg(
				$signed(rand_coord(sb.win_left, sb.win_right)),
				$signed(rand_coord(sb.win_top, sb.win_bottom)),
				$signed(rand_coord(sb.win_left, sb.win_right)),
				$signed(rand_coord(sb.win_top, sb.win_bottom))));
		end
	endtask

	initial begin
		longint a, b, c, d;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window left at its reset value, a single point at the origin
		send_segment(make_seg(0, 0, 0, 0));
		send_segment(make_seg(-5, 0, 5, 0));
		random_segments(30);

		set_window(-100, -80, 120, 90);
		tx_gaps = 0;
		rx_stalls = 0;
		send_segment(make_seg(0, 0, 10, 10));
		send_segment(make_seg(-32768, -32768, -32768, -32768));
		send_segment(make_seg(32767, 32767, 32767, 32767));
		send_segment(make_seg(-32768, 0, 32767, 0));
		send_segment(make_seg(0, -32768, 0, 32767));
		send_segment(make_seg(-32768, -32768, 32767, 32767));
		send_segment(make_seg(32767, -32768, -32768, 32767));
		send_segment(make_seg(-32768, 32767, 32767, -32768));
		send_segment(make_seg(-200, -150, 300, 250));
		send_segment(make_seg(-300, -150, 200, 300));
		send_segment(make_seg(-150, 200, 200, -300));
		send_segment(make_seg(-101, -81, 121, 91));
		send_segment(make_seg(-100, -80, 120, 90));
		send_segment(make_seg(-300, 0, -200, 50));
		send_segment(make_seg(500, -500, 600, 500));
		send_segment(make_seg(-250, 100, 50, 400));
		send_segment(make_seg(150, -200, 400, 60));
		send_segment(make_seg(0, 0, -32768, 0));
		send_segment(make_seg(-1, -1, 0, 0));
		send_segment(make_seg(21845, -21846, -21846, 21845));
		random_segments(300);

		// whole coordinate range inside
		set_window(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
		random_segments(120);

		// inverted window, nothing inside
		set_window(200, 150, -200, -150);
		random_segments(150);

		// window pushed against the far corner
		set_window(COORD_HI - 50, COORD_HI - 50, COORD_HI, COORD_HI);
		random_segments(80);

		for (int w = 0; w < 3; w++) begin
			a = longint'($signed(16'($urandom())));
			c = longint'($signed(16'($urandom())));
			if (w == 2) begin
				b = longint'($signed(16'($urandom())));
				d = longint'($signed(16'($urandom())));
			end else begin
				b = a + $urandom_range(2000);
				d = c + $urandom_range(2000);
				if (b > COORD_HI) b = COORD_HI;
				if (d > COORD_HI) d = COORD_HI;
			end
			set_window(a, c, b, d);
			random_segments(100);
		end

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d clip results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/rlc_pkg.sv
hdl/rlc_divider.sv
hdl/rlc_datapath.sv
hdl/rlc_ctrl.sv
hdl/rectangle_line_clipper_unit.sv
tb/testbench.sv
